>>> rtl/base_relocation_directory_parser_core_assert.svh
// ----------------------------------------------------------------------------
// Base relocation directory parser assertion macros
// Shared concurrent assertion forms used by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef BASE_RELOCATION_DIRECTORY_PARSER_CORE_ASSERT_SVH
`define BASE_RELOCATION_DIRECTORY_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BRDP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brdp: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define BRDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brdp: next-cycle check failed");

`endif

>>> rtl/brdp_pkg.sv
// ----------------------------------------------------------------------------
// Base relocation directory parser package
// Types, constants and codes shared by the parser front, queue and back.
// ----------------------------------------------------------------------------
package brdp_pkg;

   // Image offsets at or above 2^IMAGE_ADDR_BITS are outside the image.
   localparam int unsigned IMAGE_ADDR_BITS = 28;
   localparam logic [32:0] IMAGE_CAP = 33'd1 << IMAGE_ADDR_BITS;

   localparam int unsigned IMG_LEN_BITS = 29;

   localparam logic [31:0] HDR_BYTES = 32'd8;

   // Relocation types.
   localparam logic [3:0] TYPE_PAD     = 4'd0;
   localparam logic [3:0] TYPE_HIGHLOW = 4'd3;
   localparam logic [3:0] TYPE_DIR64   = 4'd10;

   localparam logic [11:0] ENTRY_OFFSET_MASK = 12'hFFF;

   // Result kinds.
   localparam logic [2:0] KIND_PATCH32     = 3'd0;
   localparam logic [2:0] KIND_PATCH64     = 3'd1;
   localparam logic [2:0] KIND_UNSUPPORTED = 3'd2;
   localparam logic [2:0] KIND_BAD_BLOCK   = 3'd3;
   localparam logic [2:0] KIND_DIR_OUTSIDE = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DIR_OFFSET = 2'd0;
   localparam logic [1:0] CSR_DIR_SIZE   = 2'd1;
   localparam logic [1:0] CSR_IMG_LEN    = 2'd2;
   localparam logic [1:0] CSR_LOAD_DELTA = 2'd3;

   // Event queue between front and back.
   localparam int unsigned FIFO_PTR_BITS = 2;
   localparam int unsigned FIFO_DEPTH    = 1 << FIFO_PTR_BITS;
   localparam int unsigned FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

   typedef struct packed {
      logic [7:0] dir_byte;
      logic       start_of_dir;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [31:0] target_offset;
      logic [3:0]  reloc_kind;
      logic [63:0] patch_addend;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      EV_ENTRY,
      EV_BAD_BLOCK,
      EV_DIR_OUTSIDE
   } ev_kind_type;

   // For EV_ENTRY, base is the block page address; otherwise the report offset.
   typedef struct packed {
      ev_kind_type kind;
      logic [31:0] base;
      logic [15:0] entry;
   } event_type;

   typedef struct packed {
      logic [31:0]             dir_offset;
      logic [31:0]             dir_size;
      logic [IMG_LEN_BITS-1:0] limit;
      logic [63:0]             load_delta;
      logic                    delta_zero;
   } cfg_type;

   typedef struct packed {
      logic                     valid;
      logic                     full;
      logic [FIFO_CNT_BITS-1:0] count;
   } fifo_status_type;

endpackage

>>> rtl/brdp_front.sv
// ----------------------------------------------------------------------------
// Parser front
// Walks the directory byte stream and emits directory-range errors, block errors and raw entries.
// ----------------------------------------------------------------------------
module brdp_front
   import brdp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_payload_type req,
   input  cfg_type         cfg,
   output logic            ev_push,
   output event_type       ev
);

   logic        halted_ff, halted_in;
   logic [31:0] dpos_ff, dpos_in;
   logic [31:0] page_ff, page_in;
   logic [31:0] blen_ff, blen_in;
   logic [31:0] bpos_ff, bpos_in;
   logic [7:0]  low_ff, low_in;

   logic        start;
   logic        no_work;
   logic        outside;
   logic [31:0] pos;
   logic [31:0] pos_inc;
   logic [31:0] dpos;
   logic [31:0] dpos_inc;
   logic        short_tail;
   logic [31:0] hdr_start;
   logic [31:0] remaining;
   logic [31:0] len_hdr;

   assign start      = req.start_of_dir;
   assign no_work    = (cfg.dir_offset == 32'd0) || (cfg.dir_size == 32'd0) || cfg.delta_zero;
   assign outside    = ({1'b0, cfg.dir_offset} + {1'b0, cfg.dir_size})
                       > {4'd0, cfg.limit};
   assign pos        = start ? 32'd0 : bpos_ff;
   assign dpos       = start ? 32'd0 : dpos_ff;
   assign pos_inc    = pos + 32'd1;
   assign dpos_inc   = dpos + 32'd1;
   assign short_tail = (cfg.dir_size - dpos) < HDR_BYTES;
   assign hdr_start  = dpos_inc - HDR_BYTES;
   assign remaining  = cfg.dir_size - hdr_start;
   assign len_hdr    = {req.dir_byte, blen_ff[23:0]};

   always_comb begin
      halted_in = halted_ff;
      dpos_in   = dpos_ff;
      page_in   = page_ff;
      blen_in   = blen_ff;
      bpos_in   = bpos_ff;
      low_in    = low_ff;
      ev_push   = 1'b0;
      ev        = '{kind: EV_ENTRY, base: 32'd0, entry: 16'd0};

      if (accept) begin
         if (start) begin
            halted_in = 1'b1;
            dpos_in   = 32'd0;
            page_in   = 32'd0;
            blen_in   = 32'd0;
            bpos_in   = 32'd0;
            low_in    = 8'd0;
         end

         if (start && no_work) begin
            halted_in = 1'b1;
         end else if (start && outside) begin
            ev_push = 1'b1;
            ev      = '{kind: EV_DIR_OUTSIDE, base: cfg.dir_offset, entry: 16'd0};
         end else if (start || !halted_ff) begin
            halted_in = 1'b0;
            if (pos[31:3] == 29'd0) begin
               if ((pos[2:0] == 3'd0) && short_tail) begin
                  // Not enough bytes left for another block header.
                  halted_in = 1'b1;
                  ev_push   = 1'b1;
                  ev        = '{kind: EV_BAD_BLOCK, base: cfg.dir_offset + dpos,
                                entry: 16'd0};
               end else begin
                  case (pos[2:0])
                     3'd0: page_in = {24'd0, req.dir_byte};
                     3'd1: page_in[15:8] = req.dir_byte;
                     3'd2: page_in[23:16] = req.dir_byte;
                     3'd3: page_in[31:24] = req.dir_byte;
                     3'd4: blen_in = {24'd0, req.dir_byte};
                     3'd5: blen_in[15:8] = req.dir_byte;
                     3'd6: blen_in[23:16] = req.dir_byte;
                     3'd7: blen_in[31:24] = req.dir_byte;
                     default: page_in = page_ff;
                  endcase
                  bpos_in = pos_inc;
                  dpos_in = dpos_inc;
                  if (pos[2:0] == 3'd7) begin
                     if ((len_hdr < HDR_BYTES) || (len_hdr > remaining)) begin
                        halted_in = 1'b1;
                        ev_push   = 1'b1;
                        ev        = '{kind: EV_BAD_BLOCK,
                                      base: cfg.dir_offset + hdr_start, entry: 16'd0};
                     end else if (len_hdr == HDR_BYTES) begin
                        bpos_in = 32'd0;
                        if (dpos_inc >= cfg.dir_size) begin
                           halted_in = 1'b1;
                        end
                     end
                  end
               end
            end else begin
               // Entry bytes; a trailing odd byte falls outside the even span.
               if (pos < {blen_ff[31:1], 1'b0}) begin
                  if (!pos[0]) begin
                     low_in = req.dir_byte;
                  end else begin
                     ev_push = 1'b1;
                     ev      = '{kind: EV_ENTRY, base: page_ff,
                                 entry: {req.dir_byte, low_ff}};
                  end
               end
               bpos_in = pos_inc;
               dpos_in = dpos_inc;
               if (pos_inc >= blen_ff) begin
                  bpos_in = 32'd0;
                  if (dpos_inc >= cfg.dir_size) begin
                     halted_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff <= 1'b1;
         dpos_ff   <= 32'd0;
         page_ff   <= 32'd0;
         blen_ff   <= 32'd0;
         bpos_ff   <= 32'd0;
         low_ff    <= 8'd0;
      end else begin
         halted_ff <= halted_in;
         dpos_ff   <= dpos_in;
         page_ff   <= page_in;
         blen_ff   <= blen_in;
         bpos_ff   <= bpos_in;
         low_ff    <= low_in;
      end
   end

endmodule

>>> rtl/brdp_fifo.sv
// ----------------------------------------------------------------------------
// Event queue
// Small register queue that decouples the parser front from the back.
// ----------------------------------------------------------------------------
module brdp_fifo
   import brdp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  event_type       push_ev,
   input  logic            pop,
   output event_type       head_ev,
   output fifo_status_type status
);

   event_type                mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == FIFO_CNT_BITS'(FIFO_DEPTH));
   assign status.count = count_ff;
   assign head_ev      = mem_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_ev;
      end
   end

endmodule

>>> rtl/brdp_back.sv
// ----------------------------------------------------------------------------
// Parser back
// Range-checks and classifies entries, turns error events into reports and holds the result register.
// ----------------------------------------------------------------------------
module brdp_back
   import brdp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            ev_valid,
   input  event_type       ev,
   output logic            ev_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic            valid_ff, valid_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic [32:0]     target;
   logic            in_image;
   logic [3:0]      etype;
   logic            produce;

   assign etype    = ev.entry[15:12];
   assign target   = {1'b0, ev.base} + {21'd0, ev.entry[11:0] & ENTRY_OFFSET_MASK};
   assign in_image = target < {4'd0, cfg.limit};
   assign ev_pop   = ev_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      produce = 1'b0;
      rsp_in  = rsp_ff;
      case (ev.kind)
         EV_ENTRY: begin
            if (in_image && (etype != TYPE_PAD)) begin
               produce = 1'b1;
               if (etype == TYPE_HIGHLOW) begin
                  rsp_in = '{result_kind: KIND_PATCH32, target_offset: target[31:0],
                             reloc_kind: etype,
                             patch_addend: {32'd0, cfg.load_delta[31:0]}};
               end else if (etype == TYPE_DIR64) begin
                  rsp_in = '{result_kind: KIND_PATCH64, target_offset: target[31:0],
                             reloc_kind: etype, patch_addend: cfg.load_delta};
               end else begin
                  rsp_in = '{result_kind: KIND_UNSUPPORTED, target_offset: target[31:0],
                             reloc_kind: etype, patch_addend: 64'd0};
               end
            end
         end
         EV_BAD_BLOCK: begin
            produce = 1'b1;
            rsp_in  = '{result_kind: KIND_BAD_BLOCK, target_offset: ev.base,
                        reloc_kind: 4'd0, patch_addend: 64'd0};
         end
         EV_DIR_OUTSIDE: begin
            produce = 1'b1;
            rsp_in  = '{result_kind: KIND_DIR_OUTSIDE, target_offset: ev.base,
                        reloc_kind: 4'd0, patch_addend: 64'd0};
         end
         default: produce = 1'b0;
      endcase

      if (ev_pop) begin
         valid_in = produce;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_pop && produce) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/base_relocation_directory_parser_core.sv
// ----------------------------------------------------------------------------
// Base relocation directory parser core
// Turns a streamed base-relocation directory into patch and error transactions.
// ----------------------------------------------------------------------------
// The core takes one directory byte per clock cycle while req_stall is low,
// with no gaps needed between transactions, and gives at most one result
// transaction per byte. The front walks block headers and entries at one byte
// a cycle; the back range-checks each entry from the queue and registers the
// result. A four-entry event queue sits between them, so req_stall rises only
// after four events pile up behind a stalled result port. An entry or error
// reaches rsp_valid through the event queue and then the result register.
// Program dir_offset, dir_size, the image length and load_delta through the
// csr_ port while the core is idle, then send the directory with start_of_dir
// set on its first byte. A start with a zero offset, size or delta does
// nothing; a directory that runs past the image end gives one "directory
// outside image" result. After a malformed block or the end of the directory
// the core ignores bytes until the next start.
// ----------------------------------------------------------------------------
`include "base_relocation_directory_parser_core_assert.svh"

module base_relocation_directory_parser_core
   import brdp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,

   // Directory byte transactions.
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,

   // Result transactions.
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,

   // Configuration writes.
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [63:0]     csr_wdata
);

   logic [31:0]             dir_offset_ff;
   logic [31:0]             dir_size_ff;
   logic [IMG_LEN_BITS-1:0] img_len_ff;
   logic [63:0]             load_delta_ff;

   cfg_type         cfg;
   logic            req_accept;
   logic            ev_push;
   event_type       ev_in;
   event_type       ev_head;
   logic            ev_pop;
   fifo_status_type fifo_status;

   // Register writes are always taken; csr_ready is tied high.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_offset_ff <= 32'd0;
         dir_size_ff   <= 32'd0;
         img_len_ff    <= '0;
         load_delta_ff <= 64'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DIR_OFFSET: dir_offset_ff <= csr_wdata[31:0];
            CSR_DIR_SIZE:   dir_size_ff   <= csr_wdata[31:0];
            CSR_IMG_LEN:    img_len_ff    <= csr_wdata[IMG_LEN_BITS-1:0];
            CSR_LOAD_DELTA: load_delta_ff <= csr_wdata;
            default:        load_delta_ff <= load_delta_ff;
         endcase
      end
   end

   // The usable image end is the programmed size, capped at the address space.
   always_comb begin
      cfg.dir_offset = dir_offset_ff;
      cfg.dir_size   = dir_size_ff;
      cfg.load_delta = load_delta_ff;
      cfg.delta_zero = (load_delta_ff == 64'd0);
      if ({4'd0, img_len_ff} > IMAGE_CAP) begin
         cfg.limit = IMAGE_CAP[IMG_LEN_BITS-1:0];
      end else begin
         cfg.limit = img_len_ff;
      end
   end

   // The front pushes at most one event per byte, so a full queue is the only
   // reason to hold off the byte stream.
   assign req_stall  = fifo_status.full;
   assign req_accept = req_valid && !req_stall;

   brdp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_payload),
      .cfg    (cfg),
      .ev_push(ev_push),
      .ev     (ev_in)
   );

   brdp_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (ev_push),
      .push_ev(ev_in),
      .pop    (ev_pop),
      .head_ev(ev_head),
      .status (fifo_status)
   );

   brdp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .ev_valid   (fifo_status.valid),
      .ev         (ev_head),
      .ev_pop     (ev_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   // The queue never holds more events than it has slots.
   `BRDP_ASSERT_IMPLY(a_fifo_bound, clock, reset, 1'b1,
                      fifo_status.count <= FIFO_CNT_BITS'(FIFO_DEPTH))

   // A push is never offered while the queue is full.
   `BRDP_ASSERT_IMPLY(a_no_push_when_full, clock, reset, fifo_status.full, !ev_push)

   // A 32-bit patch carries only the low half of the delta.
   `BRDP_ASSERT_IMPLY(a_patch32_addend, clock, reset,
                      rsp_valid && (rsp_payload.result_kind == KIND_PATCH32),
                      rsp_payload.patch_addend[63:32] == 32'd0)

   // Error reports carry no relocation type and no addend.
   `BRDP_ASSERT_IMPLY(a_error_fields, clock, reset,
                      rsp_valid && ((rsp_payload.result_kind == KIND_BAD_BLOCK) ||
                                    (rsp_payload.result_kind == KIND_DIR_OUTSIDE)),
                      (rsp_payload.reloc_kind == 4'd0) && (rsp_payload.patch_addend == 64'd0))

endmodule
